@@ rtl/core/five_tuple_flow_table_unit_assert.svh @@
// Assertion macros for the flow table unit.
// Included by modules that carry concurrent checks; needs no package.
`ifndef FIVE_TUPLE_FLOW_TABLE_UNIT_ASSERT_SVH
`define FIVE_TUPLE_FLOW_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define FTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("flow table check failed");

// Next-cycle implication, idle during reset.
`define FTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("flow table check failed");

`endif

@@ rtl/core/ftt_pkg.sv @@
// Shared types and codes for the five-tuple flow table.
// No dependencies.
`timescale 1ns / 1ps

package ftt_pkg;

    localparam int IDX_W   = 16;
    localparam int CELL_W  = 8;
    localparam int KEY_W   = 104;
    localparam int COUNT_W = 32;
    localparam int SLOT_W  = 10;
    localparam int STAT_W  = 3;

    localparam logic [1:0] OP_PACKET = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_EXISTING  = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW       = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_DELETED   = 3'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // read sweep, broadcast to every cell
    typedef struct packed {
        logic             rd_en;
        logic             first;
        logic [IDX_W-1:0] addr;
    } scan_t;

    // table write, to one cell or to all during the clearing pass
    typedef struct packed {
        logic              en;
        logic              all;
        logic [CELL_W-1:0] bank_sel;
        logic [IDX_W-1:0]  addr;
        entry_t            data;
    } wr_t;

    // best match so far, handed from cell to cell
    typedef struct packed {
        logic               hit_vld;
        logic [CELL_W-1:0]  hit_cell;
        logic [IDX_W-1:0]   hit_addr;
        logic [COUNT_W-1:0] hit_count;
        logic               free_vld;
        logic [CELL_W-1:0]  free_cell;
        logic [IDX_W-1:0]   free_addr;
    } chain_t;

endpackage

@@ rtl/core/five_tuple_flow_table_unit.sv @@
// Top level of the five-tuple flow table: control sequencer and cell chain.
// Uses ftt_pkg, ftt_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "five_tuple_flow_table_unit_assert.svh"

// Exact-match flow table over N_CELLS cells, each a bank of
// ceil(TABLE_ENTRIES / N_CELLS) entries. After reset a clearing pass over
// every bank address runs before the first item is taken. For each item
// the banks are swept one address per cycle in parallel, the per-cell
// results travel down the chain one cell per cycle, then the decision
// writes the table and registers the result. A new item is accepted only
// after the result has been taken; a stalled result holds the input off.
// One item is in flight at a time; in_ready is high only when idle.
module five_tuple_flow_table_unit #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int N_CELLS       = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] ip_dst,
    input  logic [31:0] ip_src,
    input  logic [15:0] l4_dst,
    input  logic [15:0] l4_src,
    input  logic [7:0]  protocol,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [9:0]  slot,
    output logic [31:0] packet_count
);

    localparam int BANK    = (TABLE_ENTRIES + N_CELLS - 1) / N_CELLS;
    localparam int AW      = (BANK > 1) ? $clog2(BANK) : 1;
    localparam int DRAIN   = N_CELLS + 1;
    localparam int DRAIN_W = $clog2(DRAIN + 1);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_OUT} state_t;

    state_t                         state_reg;
    logic [AW-1:0]                  addr_reg;
    logic [DRAIN_W-1:0]             drain_reg;
    logic [1:0]                     op_reg;
    logic [ftt_pkg::KEY_W-1:0]      key_reg;
    logic [ftt_pkg::STAT_W-1:0]     status_reg;
    logic [ftt_pkg::SLOT_W-1:0]     slot_reg;
    logic [ftt_pkg::COUNT_W-1:0]    count_reg;

    ftt_pkg::scan_t  scan;
    ftt_pkg::wr_t    wr;
    ftt_pkg::chain_t chain [N_CELLS+1];
    ftt_pkg::chain_t tail;
    logic [31:0]     hit_slot, free_slot;
    logic [ftt_pkg::COUNT_W-1:0] inc_count;

    assign chain[0] = '0;
    assign tail     = chain[N_CELLS];

    for (genvar k = 0; k < N_CELLS; k++)
    begin : g_cell
        ftt_cell #(
            .CELL_ID      (k),
            .BANK         (BANK),
            .AW           (AW),
            .TABLE_ENTRIES(TABLE_ENTRIES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .scan     (scan),
            .key      (key_reg),
            .wr       (wr),
            .chain_in (chain[k]),
            .chain_out(chain[k+1])
        );
    end

    assign hit_slot  = 32'(tail.hit_cell) * 32'(BANK) + 32'(tail.hit_addr);
    assign free_slot = 32'(tail.free_cell) * 32'(BANK) + 32'(tail.free_addr);
    assign inc_count = (tail.hit_count == ftt_pkg::COUNT_MAX) ? tail.hit_count
                                                              : tail.hit_count + 1'b1;

    always_comb
    begin
        scan       = '0;
        scan.rd_en = (state_reg == S_SCAN);
        scan.first = (state_reg == S_SCAN) && (addr_reg == '0);
        scan.addr  = ftt_pkg::IDX_W'(addr_reg);

        wr      = '0;
        wr.addr = ftt_pkg::IDX_W'(addr_reg);
        if (state_reg == S_CLEAR)
        begin
            wr.en  = 1'b1;
            wr.all = 1'b1;
        end
        else if (state_reg == S_DECIDE)
        begin
            wr.data.key = key_reg;
            case (op_reg)
                ftt_pkg::OP_PACKET:
                begin
                    if (tail.hit_vld)
                    begin
                        wr.en         = 1'b1;
                        wr.bank_sel   = tail.hit_cell;
                        wr.addr       = tail.hit_addr;
                        wr.data.valid = 1'b1;
                        wr.data.count = inc_count;
                    end
                    else if (tail.free_vld)
                    begin
                        wr.en         = 1'b1;
                        wr.bank_sel   = tail.free_cell;
                        wr.addr       = tail.free_addr;
                        wr.data.valid = 1'b1;
                        wr.data.count = ftt_pkg::COUNT_W'(1);
                    end
                end
                ftt_pkg::OP_DELETE:
                begin
                    if (tail.hit_vld)
                    begin
                        wr.en         = 1'b1;
                        wr.bank_sel   = tail.hit_cell;
                        wr.addr       = tail.hit_addr;
                        wr.data.valid = 1'b0;
                        wr.data.count = tail.hit_count;
                    end
                end
                default:
                begin
                    wr.en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            addr_reg   <= '0;
            drain_reg  <= '0;
            op_reg     <= '0;
            key_reg    <= '0;
            status_reg <= '0;
            slot_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == AW'(BANK - 1))
                    begin
                        addr_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= op;
                        key_reg   <= {ip_dst, ip_src, l4_dst, l4_src, protocol};
                        addr_reg  <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (addr_reg == AW'(BANK - 1))
                    begin
                        addr_reg  <= '0;
                        drain_reg <= '0;
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                    if (drain_reg == DRAIN_W'(DRAIN))
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    state_reg <= S_OUT;
                    case (op_reg)
                        ftt_pkg::OP_PACKET:
                        begin
                            if (tail.hit_vld)
                            begin
                                status_reg <= ftt_pkg::ST_EXISTING;
                                slot_reg   <= hit_slot[ftt_pkg::SLOT_W-1:0];
                                count_reg  <= inc_count;
                            end
                            else if (tail.free_vld)
                            begin
                                status_reg <= ftt_pkg::ST_NEW;
                                slot_reg   <= free_slot[ftt_pkg::SLOT_W-1:0];
                                count_reg  <= ftt_pkg::COUNT_W'(1);
                            end
                            else
                            begin
                                status_reg <= ftt_pkg::ST_FULL;
                                slot_reg   <= '0;
                                count_reg  <= '0;
                            end
                        end
                        default:
                        begin
                            if (tail.hit_vld)
                            begin
                                status_reg <= (op_reg == ftt_pkg::OP_DELETE) ?
                                              ftt_pkg::ST_DELETED : ftt_pkg::ST_EXISTING;
                                slot_reg   <= hit_slot[ftt_pkg::SLOT_W-1:0];
                                count_reg  <= tail.hit_count;
                            end
                            else
                            begin
                                status_reg <= ftt_pkg::ST_NOT_FOUND;
                                slot_reg   <= '0;
                                count_reg  <= '0;
                            end
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign status       = status_reg;
    assign slot         = slot_reg;
    assign packet_count = count_reg;

    `FTT_ASSERT_IMP(a_new_count_one, clk, rst_n, out_valid && status == ftt_pkg::ST_NEW, packet_count == 32'd1)
    `FTT_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && (status == ftt_pkg::ST_NOT_FOUND || status == ftt_pkg::ST_FULL), slot == 10'd0 && packet_count == 32'd0)
    `FTT_ASSERT_IMP(a_one_side, clk, rst_n, out_valid, !in_ready)
    `FTT_ASSERT_NXT(a_out_done, clk, rst_n, out_valid && out_ready, !out_valid)

endmodule

@@ rtl/core/ftt_cell.sv @@
// One cell of the flow table chain: a bank of entries, its sweep compare,
// and the hand-off of the lowest hit and lowest free entry. Uses ftt_pkg.
`timescale 1ns / 1ps

module ftt_cell #(
    parameter int CELL_ID       = 0,
    parameter int BANK          = 256,
    parameter int AW            = 8,
    parameter int TABLE_ENTRIES = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ftt_pkg::scan_t           scan,
    input  logic [ftt_pkg::KEY_W-1:0] key,
    input  ftt_pkg::wr_t             wr,
    input  ftt_pkg::chain_t          chain_in,
    output ftt_pkg::chain_t          chain_out
);

    localparam int CELL_BASE = CELL_ID * BANK;

    ftt_pkg::entry_t mem [BANK];
    ftt_pkg::entry_t rd_data_reg;
    logic            rd_vld_reg;
    logic [AW-1:0]   rd_addr_reg;

    ftt_pkg::chain_t own_reg, own_next;
    ftt_pkg::chain_t chain_reg, chain_next;
    logic            in_range;

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.all || wr.bank_sel == ftt_pkg::CELL_W'(CELL_ID)))
        begin
            mem[wr.addr[AW-1:0]] <= wr.data;
        end
        if (scan.rd_en)
        begin
            rd_data_reg <= mem[scan.addr[AW-1:0]];
        end
        rd_addr_reg <= scan.addr[AW-1:0];
    end

    assign in_range = (CELL_BASE + int'(rd_addr_reg)) < TABLE_ENTRIES;

    always_comb
    begin
        own_next = own_reg;
        if (scan.first)
        begin
            own_next.hit_vld  = 1'b0;
            own_next.free_vld = 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if (!own_reg.hit_vld && rd_data_reg.valid && rd_data_reg.key == key)
            begin
                own_next.hit_vld   = 1'b1;
                own_next.hit_addr  = ftt_pkg::IDX_W'(rd_addr_reg);
                own_next.hit_count = rd_data_reg.count;
            end
            if (!own_reg.free_vld && !rd_data_reg.valid && in_range)
            begin
                own_next.free_vld  = 1'b1;
                own_next.free_addr = ftt_pkg::IDX_W'(rd_addr_reg);
            end
        end
        own_next.hit_cell  = ftt_pkg::CELL_W'(CELL_ID);
        own_next.free_cell = ftt_pkg::CELL_W'(CELL_ID);

        // upstream cells hold lower indexes, so they win
        chain_next = chain_in;
        if (!chain_in.hit_vld)
        begin
            chain_next.hit_vld   = own_reg.hit_vld;
            chain_next.hit_cell  = own_reg.hit_cell;
            chain_next.hit_addr  = own_reg.hit_addr;
            chain_next.hit_count = own_reg.hit_count;
        end
        if (!chain_in.free_vld)
        begin
            chain_next.free_vld  = own_reg.free_vld;
            chain_next.free_cell = own_reg.free_cell;
            chain_next.free_addr = own_reg.free_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            own_reg    <= '0;
            chain_reg  <= '0;
        end
        else
        begin
            rd_vld_reg <= scan.rd_en;
            own_reg    <= own_next;
            chain_reg  <= chain_next;
        end
    end

    assign chain_out = chain_reg;

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for five_tuple_flow_table_unit: directed rows, then random
// flows over a small key pool; results are checked against a behavioral flow table.
// Depends on ftt_pkg and the unit RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int          ENTRIES   = 1024;
    localparam int          CYCLE_CAP = 1000000;
    localparam int          HOLD_LEN  = 600;
    localparam int          POOL_N    = 48;
    localparam int          RAND_N    = 560;
    localparam int          QUIET_AT  = 500;
    localparam logic [1:0]  OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]  st;
        logic [9:0]  sl;
        logic [31:0] cnt;
    } res_t;

    typedef struct packed {
        logic [1:0]   op;
        logic [103:0] key;
        logic         chk;
        res_t         res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [31:0] ip_dst;
    logic [31:0] ip_src;
    logic [15:0] l4_dst;
    logic [15:0] l4_src;
    logic [7:0]  protocol;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [9:0]  slot;
    logic [31:0] packet_count;

    // behavioral copy of the table
    logic         flow_live[ENTRIES];
    logic [103:0] flow_key[ENTRIES];
    logic [31:0]  flow_pkts[ENTRIES];

    res_t         pending_results[$];
    logic [103:0] key_pool[POOL_N];
    row_t         directed_rows[$];
    int           err_count;
    int           cycle_count;
    bit           quiet;
    bit           hold_req;

    five_tuple_flow_table_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .ip_dst(ip_dst), .ip_src(ip_src),
        .l4_dst(l4_dst), .l4_src(l4_src), .protocol(protocol),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .slot(slot), .packet_count(packet_count)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[five_tuple_flow_table_unit] ERROR");
            $finish;
        end
    end

    task automatic report(input string what);
        $display("mismatch @%0t: %s", $time, what);
        err_count++;
    endtask

    // applies one operation to the table copy and returns its result
    function automatic res_t flow_update(input logic [1:0] opc, input logic [103:0] k);
        int   i;
        int   hit;
        int   free_idx;
        res_t r;
        hit = -1;
        free_idx = -1;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && flow_live[i] && flow_key[i] == k)
                hit = i;
            if (free_idx < 0 && !flow_live[i])
                free_idx = i;
        end
        r = '0;
        r.st = ftt_pkg::ST_NOT_FOUND;
        if (opc == ftt_pkg::OP_PACKET)
        begin
            if (hit >= 0)
            begin
                if (flow_pkts[hit] != ftt_pkg::COUNT_MAX)
                    flow_pkts[hit] = flow_pkts[hit] + 1;
                r.st = ftt_pkg::ST_EXISTING;
                r.sl = hit[9:0];
                r.cnt = flow_pkts[hit];
            end
            else if (free_idx < 0)
                r.st = ftt_pkg::ST_FULL;
            else
            begin
                flow_live[free_idx] = 1'b1;
                flow_key[free_idx] = k;
                flow_pkts[free_idx] = 32'd1;
                r.st = ftt_pkg::ST_NEW;
                r.sl = free_idx[9:0];
                r.cnt = 32'd1;
            end
        end
        else if (opc == ftt_pkg::OP_DELETE)
        begin
            if (hit >= 0)
            begin
                flow_live[hit] = 1'b0;
                r.st = ftt_pkg::ST_DELETED;
                r.sl = hit[9:0];
                r.cnt = flow_pkts[hit];
            end
        end
        else if (hit >= 0)
        begin
            r.st = ftt_pkg::ST_EXISTING;
            r.sl = hit[9:0];
            r.cnt = flow_pkts[hit];
        end
        return r;
    endfunction

    // drive one item, wait for acceptance, then queue its expected result
    task automatic send_item(input logic [1:0] opc, input logic [103:0] k,
                             input bit chk, input res_t typed);
        int   g;
        res_t r;
        if (!quiet && $urandom_range(0, 9) < 3)
        begin
            g = $urandom_range(1, 10);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        op = opc;
        {ip_dst, ip_src, l4_dst, l4_src, protocol} = k;
        do
            @(posedge clk);
        while (!in_ready);
        r = flow_update(opc, k);
        if (chk && r != typed)
            report($sformatf("table copy disagrees with typed row: %h vs %h", r, typed));
        pending_results.push_back(chk ? typed : r);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [103:0] rand_key();
        return {$urandom(), $urandom(), $urandom(), 8'($urandom())};
    endfunction

    function automatic logic [103:0] pick_key();
        int sel;
        logic [103:0] k;
        sel = $urandom_range(0, 9);
        k = key_pool[$urandom_range(0, POOL_N - 1)];
        if (sel < 6)
            return k;
        if (sel < 8)
        begin
            k[$urandom_range(0, 103)] ^= 1'b1;
            return k;
        end
        return rand_key();
    endfunction

    function automatic row_t mk_row(input logic [1:0] opc, input logic [103:0] k,
                                    input bit chk, input logic [2:0] st,
                                    input logic [9:0] sl, input logic [31:0] cnt);
        row_t rw;
        rw.op = opc;
        rw.key = k;
        rw.chk = chk;
        rw.res = '{st: st, sl: sl, cnt: cnt};
        return rw;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report("result with nothing expected");
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                    report($sformatf("status %0d, expected %0d", status, e.st));
                if (slot !== e.sl)
                    report($sformatf("slot %0d, expected %0d", slot, e.sl));
                if (packet_count !== e.cnt)
                    report($sformatf("packet_count %0d, expected %0d",
                                     packet_count, e.cnt));
            end
        end
    end

    // result-side backpressure
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready = 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (quiet)
                out_ready = 1'b1;
            else
            begin
                n = $urandom_range(1, 10);
                out_ready = ($urandom_range(0, 9) < 7);
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    initial
    begin
        logic [103:0] ka;
        logic [103:0] ones;
        int i;
        int opsel;
        logic [1:0] opc;

        rst_n = 1'b0;
        in_valid = 1'b0;
        op = '0;
        {ip_dst, ip_src, l4_dst, l4_src, protocol} = '0;
        err_count = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        for (i = 0; i < ENTRIES; i++)
        begin
            flow_live[i] = 1'b0;
            flow_key[i] = '0;
            flow_pkts[i] = '0;
        end
        for (i = 0; i < POOL_N; i++)
            key_pool[i] = rand_key();
        ones = '1;
        ka = rand_key();

        directed_rows.push_back(mk_row(ftt_pkg::OP_SEARCH, '0, 1, ftt_pkg::ST_NOT_FOUND, 0, 0));
        directed_rows.push_back(mk_row(ftt_pkg::OP_DELETE, '0, 1, ftt_pkg::ST_NOT_FOUND, 0, 0));
        directed_rows.push_back(mk_row(ftt_pkg::OP_PACKET, '0, 1, ftt_pkg::ST_NEW, 0, 1));
        directed_rows.push_back(mk_row(ftt_pkg::OP_PACKET, '0, 1, ftt_pkg::ST_EXISTING, 0, 2));
        directed_rows.push_back(mk_row(ftt_pkg::OP_PACKET, ones, 1, ftt_pkg::ST_NEW, 1, 1));
        directed_rows.push_back(mk_row(ftt_pkg::OP_SEARCH, ones, 1, ftt_pkg::ST_EXISTING, 1, 1));
        directed_rows.push_back(mk_row(OP_UNUSED, ones, 1, ftt_pkg::ST_EXISTING, 1, 1));
        directed_rows.push_back(mk_row(ftt_pkg::OP_DELETE, '0, 1, ftt_pkg::ST_DELETED, 0, 2));
        directed_rows.push_back(mk_row(ftt_pkg::OP_SEARCH, '0, 1, ftt_pkg::ST_NOT_FOUND, 0, 0));
        // freed slot 0 is the lowest free one again
        directed_rows.push_back(mk_row(ftt_pkg::OP_PACKET, ka, 1, ftt_pkg::ST_NEW, 0, 1));
        directed_rows.push_back(mk_row(ftt_pkg::OP_PACKET, {ones[103:8], 8'hFE}, 1,
                                       ftt_pkg::ST_NEW, 2, 1));
        directed_rows.push_back(mk_row(ftt_pkg::OP_PACKET, {32'h0, ones[71:0]}, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ftt_pkg::OP_PACKET, {ones[103:72], 72'h0}, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ftt_pkg::OP_PACKET, ka, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ftt_pkg::OP_SEARCH, ka, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(ftt_pkg::OP_DELETE, ones, 1, ftt_pkg::ST_DELETED, 1, 1));
        directed_rows.push_back(mk_row(OP_UNUSED, ones, 1, ftt_pkg::ST_NOT_FOUND, 0, 0));
        directed_rows.push_back(mk_row(ftt_pkg::OP_DELETE, ones, 1, ftt_pkg::ST_NOT_FOUND, 0, 0));
        directed_rows.push_back(mk_row(ftt_pkg::OP_DELETE, ka, 0, 0, 0, 0));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].op, directed_rows[r].key,
                      directed_rows[r].chk, directed_rows[r].res);
        drain();

        // random flows over a small key pool so most items hit
        for (i = 0; i < RAND_N; i++)
        begin
            if (i == 100)
                hold_req = 1'b1;
            if (i == 300)
                drain();
            if (i == QUIET_AT)
                quiet = 1'b1;
            opsel = $urandom_range(0, 9);
            opc = (opsel < 5) ? ftt_pkg::OP_PACKET : (opsel < 7) ? ftt_pkg::OP_SEARCH :
                  (opsel < 9) ? ftt_pkg::OP_DELETE : OP_UNUSED;
            send_item(opc, pick_key(), 0, '0);
        end
        drain();

        if (err_count == 0)
            $display("[five_tuple_flow_table_unit] OK");
        else
            $display("[five_tuple_flow_table_unit] ERROR");
        $finish;
    end

endmodule
